// ===== hw/rtl/kclc_pkg.sv =====
`timescale 1ns / 1ps

package kclc_pkg;

    // entry and stored code depth
    localparam int MAX_DIGITS = 32;
    localparam int ADDR_W     = $clog2(MAX_DIGITS);
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int DIGIT_W    = 4;

    // stored code after reset: this many ones, the rest zero
    localparam logic [CNT_W-1:0]   CODE_INIT_LEN   = CNT_W'(4);
    localparam logic [DIGIT_W-1:0] CODE_INIT_DIGIT = DIGIT_W'(1);

    typedef enum logic [2:0] {
        OP_DIGIT  = 3'd0,
        OP_ENTER  = 3'd1,
        OP_ERASE  = 3'd2,
        OP_CHANGE = 3'd3,
        OP_LOCK   = 3'd4
    } op_t;

    typedef enum logic [3:0] {
        M_ENTRY      = 4'd0,
        M_LOCKED     = 4'd1,
        M_OPENED     = 4'd2,
        M_DENIED     = 4'd3,
        M_PLEASE     = 4'd4,
        M_OLD        = 4'd5,
        M_OLD_BAD    = 4'd6,
        M_NEW        = 4'd7,
        M_EXIT       = 4'd9,
        M_OLD_PLEASE = 4'd10
    } mode_t;

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_CMP,
        CTL_COPY
    } ctl_state_t;

    localparam logic [3:0] SCR_ENTRY   = 4'd0;
    localparam logic [3:0] SCR_LOCKED  = 4'd1;
    localparam logic [3:0] SCR_OPENED  = 4'd2;
    localparam logic [3:0] SCR_DENIED  = 4'd3;
    localparam logic [3:0] SCR_PLEASE  = 4'd4;
    localparam logic [3:0] SCR_OLD     = 4'd5;
    localparam logic [3:0] SCR_OLD_BAD = 4'd6;
    localparam logic [3:0] SCR_NEW     = 4'd7;
    localparam logic [3:0] SCR_SAVED   = 4'd8;
    localparam logic [3:0] SCR_EXIT    = 4'd9;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [DIGIT_W-1:0] key_digit;
    } key_item_t;

    typedef struct packed {
        logic               door_open;
        logic [3:0]         screen_message;
        logic [DIGIT_W-1:0] echo_digit;
        logic [5:0]         digits_entered;
        logic               entry_overflow;
    } res_item_t;

    function automatic logic [3:0] mode_screen(input mode_t m);
        logic [3:0] s;
        unique case (m)
            M_ENTRY:      s = SCR_ENTRY;
            M_LOCKED:     s = SCR_LOCKED;
            M_OPENED:     s = SCR_OPENED;
            M_DENIED:     s = SCR_DENIED;
            M_PLEASE:     s = SCR_PLEASE;
            M_OLD:        s = SCR_OLD;
            M_OLD_BAD:    s = SCR_OLD_BAD;
            M_NEW:        s = SCR_NEW;
            M_EXIT:       s = SCR_EXIT;
            M_OLD_PLEASE: s = SCR_PLEASE;
            default:      s = SCR_ENTRY;
        endcase
        return s;
    endfunction

endpackage

// ===== hw/rtl/keypad_code_lock_controller.sv =====
`timescale 1ns / 1ps
// digit, erase, change and lock keys: the result is registered on accept,
//   and so is enter when the entry is empty or its length differs from the stored code
// enter with an equal-length entry, and enter that saves a new code: a sweep over the N
//   entered digits, one digit per cycle, compare stops at the first differing digit
// throughput: one item per cycle for short keys while each result is taken; busy for the sweep otherwise
// reset: mode shows the locked notice, entry empty, stored code 1111 (no clearing pass)

module keypad_code_lock_controller
    import kclc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      key_valid,
    output logic      key_ready,
    input  key_item_t key_item,
    output logic      res_valid,
    input  logic      res_ready,
    output res_item_t res_item
);

    // ------------------------------------------------------------------
    // control and status registers
    // ------------------------------------------------------------------
    ctl_state_t         state_reg, state_next;
    mode_t              mode_reg, mode_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   len_reg, len_next;
    logic [ADDR_W-1:0]  idx_reg, idx_next;

    // result register parts the key side from the result side
    logic               res_valid_reg, res_valid_next;
    res_item_t          res_reg, res_next;
    logic               res_load;

    // ------------------------------------------------------------------
    // memories: typed entry and stored code, registered read
    // ------------------------------------------------------------------
    logic [DIGIT_W-1:0] entry_mem [MAX_DIGITS];
    logic [DIGIT_W-1:0] code_mem  [MAX_DIGITS];

    // per-place valid bits give the stored code its reset value without a clear sweep
    logic [MAX_DIGITS-1:0] code_vld_reg;

    logic                  entry_we;
    logic [ADDR_W-1:0]     entry_wa, entry_ra;
    logic [DIGIT_W-1:0]    entry_wd;
    logic [DIGIT_W-1:0]    entry_q_reg;

    logic                  code_we;
    logic [ADDR_W-1:0]     code_wa, code_ra;
    logic [DIGIT_W-1:0]    code_wd;
    logic [DIGIT_W-1:0]    code_q_reg;
    logic                  code_vq_reg;
    logic [DIGIT_W-1:0]    code_dq_reg;
    logic [DIGIT_W-1:0]    code_digit;

    logic                  accept;
    logic                  start_cmp;
    logic                  start_copy;
    logic                  sweep_last;
    logic                  cmp_miss;
    logic                  cmp_done;
    logic                  digit_ok;
    logic                  entry_full;

    assign accept    = key_valid && key_ready;
    assign key_ready = (state_reg == CTL_IDLE) && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res_item  = res_reg;

    // unwritten code places read as the reset code
    assign code_digit = code_vq_reg ? code_q_reg : code_dq_reg;

    assign sweep_last = ({1'b0, idx_reg} + CNT_W'(1)) == count_reg;
    assign cmp_miss   = entry_q_reg != code_digit;
    assign cmp_done   = cmp_miss || sweep_last;

    assign digit_ok   = (key_item.key_digit >= DIGIT_W'(1)) && (key_item.key_digit <= DIGIT_W'(9));
    assign entry_full = count_reg >= CNT_W'(MAX_DIGITS);

    always_ff @(posedge clk)
    begin
        if (entry_we)
        begin
            entry_mem[entry_wa] <= entry_wd;
        end
        entry_q_reg <= entry_mem[entry_ra];
    end

    always_ff @(posedge clk)
    begin
        if (code_we)
        begin
            code_mem[code_wa] <= code_wd;
        end
        code_q_reg  <= code_mem[code_ra];
        code_vq_reg <= code_vld_reg[code_ra];
        code_dq_reg <= ({1'b0, code_ra} < CODE_INIT_LEN) ? CODE_INIT_DIGIT : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_vld_reg <= '0;
        end
        else if (code_we)
        begin
            code_vld_reg[code_wa] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // sequencer next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CTL_IDLE:
            begin
                if (accept && start_cmp)
                begin
                    state_next = CTL_CMP;
                end
                else if (accept && start_copy)
                begin
                    state_next = CTL_COPY;
                end
            end
            CTL_CMP:
            begin
                if (cmp_done)
                begin
                    state_next = CTL_IDLE;
                end
            end
            CTL_COPY:
            begin
                if (sweep_last)
                begin
                    state_next = CTL_IDLE;
                end
            end
            default: state_next = CTL_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // key decode, sweeps and result
    // ------------------------------------------------------------------
    always_comb
    begin
        mode_next      = mode_reg;
        count_next     = count_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        start_cmp      = 1'b0;
        start_copy     = 1'b0;
        res_load       = 1'b0;
        res_next       = res_reg;
        entry_we       = 1'b0;
        entry_wa       = count_reg[ADDR_W-1:0];
        entry_wd       = key_item.key_digit;
        entry_ra       = '0;
        code_we        = 1'b0;
        code_wa        = idx_reg;
        code_wd        = entry_q_reg;
        code_ra        = '0;

        res_next.echo_digit     = '0;
        res_next.entry_overflow = 1'b0;

        unique case (state_reg)
            CTL_IDLE:
            begin
                idx_next = '0;
                if (accept)
                begin
                    res_load = 1'b1;
                    unique case (mode_reg)
                        M_ENTRY, M_OLD, M_NEW:
                        begin
                            unique case (key_item.opcode)
                                OP_DIGIT:
                                begin
                                    if (digit_ok)
                                    begin
                                        if (entry_full)
                                        begin
                                            res_next.entry_overflow = 1'b1;
                                        end
                                        else
                                        begin
                                            entry_we            = 1'b1;
                                            count_next          = count_reg + CNT_W'(1);
                                            res_next.echo_digit = key_item.key_digit;
                                        end
                                    end
                                end
                                OP_ENTER:
                                begin
                                    if (mode_reg == M_NEW)
                                    begin
                                        // empty new code is ignored
                                        if (count_reg != '0)
                                        begin
                                            start_copy = 1'b1;
                                            res_load   = 1'b0;
                                        end
                                    end
                                    else if (count_reg == '0)
                                    begin
                                        mode_next = (mode_reg == M_ENTRY) ? M_PLEASE
                                                                          : M_OLD_PLEASE;
                                    end
                                    else if (count_reg != len_reg)
                                    begin
                                        mode_next = (mode_reg == M_ENTRY) ? M_DENIED
                                                                          : M_OLD_BAD;
                                    end
                                    else
                                    begin
                                        start_cmp = 1'b1;
                                        res_load  = 1'b0;
                                    end
                                end
                                OP_ERASE:
                                begin
                                    if (mode_reg == M_ENTRY)
                                    begin
                                        count_next = '0;
                                    end
                                end
                                OP_CHANGE:
                                begin
                                    if (mode_reg == M_ENTRY)
                                    begin
                                        count_next = '0;
                                        mode_next  = M_OLD;
                                    end
                                    else if (mode_reg == M_OLD)
                                    begin
                                        mode_next = M_EXIT;
                                    end
                                end
                                default: ;
                            endcase
                        end
                        M_LOCKED, M_DENIED, M_PLEASE, M_EXIT:
                        begin
                            if (key_item.opcode == OP_ERASE)
                            begin
                                count_next = '0;
                                mode_next  = M_ENTRY;
                            end
                        end
                        M_OLD_BAD, M_OLD_PLEASE:
                        begin
                            if (key_item.opcode == OP_ERASE)
                            begin
                                count_next = '0;
                                mode_next  = M_OLD;
                            end
                        end
                        M_OPENED:
                        begin
                            if (key_item.opcode == OP_LOCK)
                            begin
                                mode_next = M_LOCKED;
                            end
                        end
                        default: mode_next = M_ENTRY;
                    endcase
                end
            end
            CTL_CMP:
            begin
                // digit idx_reg of both memories is on the read ports
                idx_next = idx_reg + ADDR_W'(1);
                entry_ra = idx_reg + ADDR_W'(1);
                code_ra  = idx_reg + ADDR_W'(1);
                if (cmp_done)
                begin
                    res_load = 1'b1;
                    if (mode_reg == M_ENTRY)
                    begin
                        mode_next = cmp_miss ? M_DENIED : M_OPENED;
                    end
                    else if (cmp_miss)
                    begin
                        mode_next = M_OLD_BAD;
                    end
                    else
                    begin
                        mode_next  = M_NEW;
                        count_next = '0;
                    end
                end
            end
            CTL_COPY:
            begin
                // move the new code into the stored code, one digit a cycle
                code_we  = 1'b1;
                idx_next = idx_reg + ADDR_W'(1);
                entry_ra = idx_reg + ADDR_W'(1);
                if (sweep_last)
                begin
                    res_load   = 1'b1;
                    len_next   = count_reg;
                    count_next = '0;
                    mode_next  = M_ENTRY;
                end
            end
            default: ;
        endcase

        res_next.door_open      = mode_next == M_OPENED;
        res_next.screen_message = (state_reg == CTL_COPY) ? SCR_SAVED : mode_screen(mode_next);
        res_next.digits_entered = 6'(count_next);

        res_valid_next = res_valid_reg;
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CTL_IDLE;
            mode_reg      <= M_LOCKED;
            count_reg     <= '0;
            len_reg       <= CODE_INIT_LEN;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            count_reg     <= count_next;
            len_reg       <= len_next;
            idx_reg       <= idx_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res_next;
        end
    end

endmodule
